// ===== hw/rtl/h2r_pkg.sv =====
// Shared types and constants for the HSL to RGB converter.
`default_nettype none

package h2r_pkg;

  // One input transaction: hue in whole degrees, saturation and lightness in Q1.16.
  typedef struct packed {
    logic [8:0]  hue_deg;
    logic [16:0] saturation;
    logic [16:0] lightness;
  } in_t;

  // One result transaction: 8-bit RGB triple.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_t;

  localparam int unsigned N_W = 40;

  localparam logic [16:0] Q_ONE  = 17'h10000;
  localparam logic [16:0] Q_HALF = 17'h08000;

  localparam logic [8:0] FULL_TURN = 9'd360;
  localparam logic [8:0] DEG_60    = 9'd60;
  localparam logic [8:0] DEG_120   = 9'd120;
  localparam logic [8:0] DEG_180   = 9'd180;
  localparam logic [8:0] DEG_240   = 9'd240;
  localparam logic [8:0] DEG_300   = 9'd300;

  // 60-degree hue sectors.
  localparam logic [2:0] SEC_RED_YEL  = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN  = 3'd1;
  localparam logic [2:0] SEC_GRN_CYAN = 3'd2;
  localparam logic [2:0] SEC_CYAN_BLU = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG  = 3'd4;
  localparam logic [2:0] SEC_MAG_RED  = 3'd5;

  localparam logic [7:0] CHAN_MAX = 8'd255;

endpackage

`default_nettype wire

// ===== hw/rtl/h2r_chan_scale.sv =====
// Final scaling of one channel numerator to an 8-bit value with clamping.
`default_nettype none

module h2r_chan_scale (
  input  wire logic [h2r_pkg::N_W-1:0] num,
  output logic [7:0]                   chan
);

  // The value is floor(17 * num / 2^35), since 255 / 60 reduces to 17 / 4.
  logic [h2r_pkg::N_W+4:0] prod;
  logic [9:0]              level;

  assign prod  = {num, 4'b0000} + {5'b00000, num};
  assign level = prod[h2r_pkg::N_W+4:h2r_pkg::N_W-5];
  assign chan  = (level > {2'b00, h2r_pkg::CHAN_MAX}) ? h2r_pkg::CHAN_MAX : level[7:0];

endmodule

`default_nettype wire

// ===== hw/rtl/hsl_to_rgb_converter_unit.sv =====
// Top level of the pipelined HSL to RGB converter.
`default_nettype none

// HSL to RGB converter. Each input transaction carries a hue in whole degrees
// (360 to 511 wrap by one turn), a saturation and a lightness in unsigned Q1.16
// (values above 65536 saturate to 1.0). Each one yields exactly one RGB
// transaction with 8-bit channels equal to floor((channel + m) * 255), computed
// exactly in integer arithmetic with no intermediate rounding. The datapath is
// a five-stage pipeline: operand conditioning and sector decode, the 17x17
// chroma multiply, the secondary weight multiply, the channel numerator sums,
// and the final scale and clamp into the output register. out_valid rises once a
// transaction has passed stage registers 1 to 4 into the output register, and
// one transaction is accepted every clock while in_stall is low. When out_stall
// holds a waiting result, the whole pipeline freezes and in_stall is raised in
// the same cycle, so nothing is dropped or repeated. Reset clears the valid
// bits only.
module hsl_to_rgb_converter_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire h2r_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output h2r_pkg::out_t       out_data
);

  // Stage valid bits.
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;

  // The pipeline moves as one unit whenever the output register is free or taken.
  logic advance;
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  // Stage 1: clamp the operands, wrap the hue, find the sector and the chroma
  // factor a = 1 - |2L - 1| in Q1.16.
  logic [16:0] s_nxt, l_nxt, a_nxt;
  logic [17:0] a_wide;
  logic [8:0]  h_nxt;
  logic [2:0]  sec_nxt;

  logic [16:0] s1_r, l1_r, a1_r;
  logic [8:0]  h1_r;
  logic [2:0]  sec1_r;

  always_comb begin
    s_nxt = (in_data.saturation > h2r_pkg::Q_ONE) ? h2r_pkg::Q_ONE : in_data.saturation;
    l_nxt = (in_data.lightness > h2r_pkg::Q_ONE) ? h2r_pkg::Q_ONE : in_data.lightness;
    h_nxt = (in_data.hue_deg >= h2r_pkg::FULL_TURN) ?
            (in_data.hue_deg - h2r_pkg::FULL_TURN) : in_data.hue_deg;

    // Below half lightness the factor is 2L, above it 2 - 2L.
    if (l_nxt <= h2r_pkg::Q_HALF) begin
      a_wide = {l_nxt, 1'b0};
    end else begin
      a_wide = 18'h20000 - {l_nxt, 1'b0};
    end
    a_nxt = a_wide[16:0];

    if (h_nxt < h2r_pkg::DEG_60) begin
      sec_nxt = h2r_pkg::SEC_RED_YEL;
    end else if (h_nxt < h2r_pkg::DEG_120) begin
      sec_nxt = h2r_pkg::SEC_YEL_GRN;
    end else if (h_nxt < h2r_pkg::DEG_180) begin
      sec_nxt = h2r_pkg::SEC_GRN_CYAN;
    end else if (h_nxt < h2r_pkg::DEG_240) begin
      sec_nxt = h2r_pkg::SEC_CYAN_BLU;
    end else if (h_nxt < h2r_pkg::DEG_300) begin
      sec_nxt = h2r_pkg::SEC_BLU_MAG;
    end else begin
      sec_nxt = h2r_pkg::SEC_MAG_RED;
    end
  end

  // Stage 2: chroma numerator cn = a * S with scale 2^32, and the triangle
  // weight k in 0..60 that shapes the secondary component.
  logic [33:0] cn_prod;
  logic [32:0] cn_nxt;
  logic [8:0]  k_wide;
  logic [5:0]  k_nxt;

  logic [32:0] cn2_r;
  logic [16:0] l2_r;
  logic [5:0]  k2_r;
  logic [2:0]  sec2_r;

  always_comb begin
    cn_prod = a1_r * s1_r;
    cn_nxt  = cn_prod[32:0];
    case (sec1_r)
      h2r_pkg::SEC_RED_YEL:  k_wide = h1_r;
      h2r_pkg::SEC_YEL_GRN:  k_wide = h2r_pkg::DEG_120 - h1_r;
      h2r_pkg::SEC_GRN_CYAN: k_wide = h1_r - h2r_pkg::DEG_120;
      h2r_pkg::SEC_CYAN_BLU: k_wide = h2r_pkg::DEG_240 - h1_r;
      h2r_pkg::SEC_BLU_MAG:  k_wide = h1_r - h2r_pkg::DEG_240;
      h2r_pkg::SEC_MAG_RED:  k_wide = h2r_pkg::FULL_TURN - h1_r;
      default:               k_wide = '0;
    endcase
    k_nxt = k_wide[5:0];
  end

  // Stage 3: Z = 2^17 * L - cn (never negative for clamped operands) and the
  // secondary term 2k * cn.
  logic [33:0]              z_nxt;
  logic [h2r_pkg::N_W-1:0]  xw_nxt;

  logic [33:0]              z3_r;
  logic [32:0]              cn3_r;
  logic [h2r_pkg::N_W-1:0]  xw3_r;
  logic [2:0]               sec3_r;

  always_comb begin
    z_nxt  = {l2_r, 17'b0} - {1'b0, cn2_r};
    xw_nxt = {7'b0, cn2_r} * {33'b0, k2_r, 1'b0};
  end

  // Stage 4: channel numerators N = 60 * Z + w * cn, where w is 120 for the
  // chroma channel, 2k for the secondary one and zero for the remaining one.
  logic [h2r_pkg::N_W-1:0] z60, c120;
  logic [h2r_pkg::N_W-1:0] nc_nxt, nx_nxt;

  logic [h2r_pkg::N_W-1:0] nc4_r, nx4_r, nz4_r;
  logic [2:0]              sec4_r;

  always_comb begin
    z60    = {z3_r, 6'b0} - {4'b0, z3_r, 2'b0};
    c120   = {cn3_r, 7'b0} - {4'b0, cn3_r, 3'b0};
    nc_nxt = z60 + c120;
    nx_nxt = z60 + xw3_r;
  end

  // Stage 5: place the three numerators on red, green and blue by sector,
  // then scale and clamp each into the output register.
  logic [h2r_pkg::N_W-1:0] nr, ng, nb;
  logic [7:0]              red_nxt, green_nxt, blue_nxt;
  h2r_pkg::out_t           out_data_r;

  always_comb begin
    case (sec4_r)
      h2r_pkg::SEC_RED_YEL: begin
        nr = nc4_r; ng = nx4_r; nb = nz4_r;
      end
      h2r_pkg::SEC_YEL_GRN: begin
        nr = nx4_r; ng = nc4_r; nb = nz4_r;
      end
      h2r_pkg::SEC_GRN_CYAN: begin
        nr = nz4_r; ng = nc4_r; nb = nx4_r;
      end
      h2r_pkg::SEC_CYAN_BLU: begin
        nr = nz4_r; ng = nx4_r; nb = nc4_r;
      end
      h2r_pkg::SEC_BLU_MAG: begin
        nr = nx4_r; ng = nz4_r; nb = nc4_r;
      end
      default: begin
        nr = nc4_r; ng = nz4_r; nb = nx4_r;
      end
    endcase
  end

  h2r_chan_scale u_scale_red   (.num(nr), .chan(red_nxt));
  h2r_chan_scale u_scale_green (.num(ng), .chan(green_nxt));
  h2r_chan_scale u_scale_blue  (.num(nb), .chan(blue_nxt));

  // Valid bits follow the data and hold while the pipeline is frozen.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r   <= s_nxt;
      l1_r   <= l_nxt;
      a1_r   <= a_nxt;
      h1_r   <= h_nxt;
      sec1_r <= sec_nxt;

      cn2_r  <= cn_nxt;
      l2_r   <= l1_r;
      k2_r   <= k_nxt;
      sec2_r <= sec1_r;

      z3_r   <= z_nxt;
      cn3_r  <= cn2_r;
      xw3_r  <= xw_nxt;
      sec3_r <= sec2_r;

      nc4_r  <= nc_nxt;
      nx4_r  <= nx_nxt;
      nz4_r  <= z60;
      sec4_r <= sec3_r;

      out_data_r.red   <= red_nxt;
      out_data_r.green <= green_nxt;
      out_data_r.blue  <= blue_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/h2r_checker.sv =====
// Port-level assertions for the HSL to RGB converter and their bind.
`default_nettype none

module h2r_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire h2r_pkg::out_t out_data
);

  // A stalled result transaction stays offered.
  a_out_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction withdrawn while stalled");

  // A stalled result transaction keeps its payload.
  a_out_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // The input side is only held off by a waiting, stalled result.
  a_in_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Reset empties the pipeline.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // An offered result always carries a fully known payload.
  a_out_known : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_data))
    else $error("result payload unknown while offered");

endmodule

bind hsl_to_rgb_converter_unit h2r_checker u_h2r_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
